### src/dmpt_pkg.sv
// ----------------------------------------------------------------------------
// dmpt_pkg
// Shared codes, types and helpers of the deadline-monotonic priority table.
// ----------------------------------------------------------------------------
package dmpt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_RESCHED = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_GAP    = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [1:0] CLS_NRT      = 2'd0;
  localparam logic [1:0] CLS_APER     = 2'd1;
  localparam logic [1:0] CLS_PERIODIC = 2'd2;
  localparam logic [1:0] CLS_SPORADIC = 2'd3;

  // ordering groups, lower sorts first
  localparam logic [1:0] GRP_PERIODIC = 2'd0;
  localparam logic [1:0] GRP_APER     = 2'd1;
  localparam logic [1:0] GRP_NRT      = 2'd2;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_NOT_FOUND,
    RES_REMOVED,
    RES_FULL,
    RES_NO_GAP,
    RES_ADDED
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SELECT,
    S_REMOVE,
    S_ADD,
    S_RESTORE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     scan;
    logic     select;
    logic     select_rem;
    logic     remove;
    logic     insert_new;
    logic     insert_saved;
    logic     publish;
    res_sel_t res;
  } dmpt_cmd_t;

  typedef struct packed {
    req_t req;
    logic found;
    logic full;
    logic no_gap;
  } dmpt_stat_t;

  function automatic logic [1:0] group_of(input logic [1:0] cls);
    logic [1:0] grp;
    if (cls >= CLS_PERIODIC) grp = GRP_PERIODIC;
    else if (cls == CLS_APER) grp = GRP_APER;
    else grp = GRP_NRT;
    return grp;
  endfunction

endpackage

### src/dmpt_ctrl.sv
// ----------------------------------------------------------------------------
// dmpt_ctrl
// Request sequencer: scan, select, remove/insert, restore and result hand-off.
// ----------------------------------------------------------------------------
module dmpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  dmpt_pkg::dmpt_stat_t  stat,
  output dmpt_pkg::dmpt_cmd_t   cmd
);
  import dmpt_pkg::*;

  state_t state, state_next;
  logic   phase, phase_next;          // set during the add half of a reschedule
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res        = RES_HOLD;
    state_next     = state;
    phase_next     = phase;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          phase_next = 1'b0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.select     = 1'b1;
        cmd.select_rem = !phase;
        if (phase) begin
          state_next = S_ADD;
        end else begin
          case (stat.req)
            REQ_ADD:     state_next = S_ADD;
            REQ_REMOVE:  state_next = S_REMOVE;
            REQ_RESCHED: state_next = S_REMOVE;
            default: begin
              cmd.res    = RES_ZERO;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_REMOVE: begin
        if (!stat.found) begin
          cmd.res    = RES_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.remove = 1'b1;
          cmd.res    = RES_REMOVED;
          if (stat.req == REQ_RESCHED) begin
            phase_next = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ADD: begin
        if (stat.full) begin
          cmd.res    = RES_FULL;
          state_next = S_DONE;
        end else if (stat.no_gap) begin
          cmd.res    = RES_NO_GAP;
          state_next = phase ? S_RESTORE : S_DONE;
        end else begin
          cmd.insert_new = 1'b1;
          cmd.res        = RES_ADDED;
          state_next     = S_DONE;
        end
      end
      S_RESTORE: begin
        // put the removed entry back where it was
        cmd.insert_saved = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_publish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over an untaken word");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN))
    else $error("accepted word did not start a scan");

  a_restore_resched: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_saved |-> (phase && $past(state) == S_ADD))
    else $error("restore outside a failed reschedule");

endmodule

### src/dmpt_datapath.sv
// ----------------------------------------------------------------------------
// dmpt_datapath
// Sorted task table as a shift chain of cells, with per-cell compare,
// neighbor selection, midpoint priority and result registers.
// ----------------------------------------------------------------------------
module dmpt_datapath #(
  parameter int MAX_TASKS = 32,
  parameter int MAX_PRIO  = 256,
  parameter int TIME_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dmpt_pkg::dmpt_cmd_t   cmd,
  output dmpt_pkg::dmpt_stat_t  stat,
  input  logic [1:0]            req_type,
  input  logic [7:0]            task_id,
  input  logic [1:0]            task_class,
  input  logic [TIME_BITS-1:0]  deadline,
  input  logic [TIME_BITS-1:0]  period_or_frame,
  output logic [1:0]            status,
  output logic [7:0]            assigned_priority,
  output logic [5:0]            position
);
  import dmpt_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(MAX_PRIO);
  localparam logic [PW:0]   PRIO_TOP = (PW + 1)'(MAX_PRIO);
  localparam logic [PW-1:0] PRIO_NRT = PW'(MAX_PRIO - 1);

  typedef struct packed {
    logic [7:0]           id;
    logic [1:0]           cls;
    logic [TIME_BITS-1:0] dl;
    logic [TIME_BITS-1:0] per;
    logic [PW-1:0]        prio;
  } entry_t;

  // request word
  req_t                 q_req;
  logic [7:0]           q_id;
  logic [1:0]           q_cls;
  logic [TIME_BITS-1:0] q_dl;
  logic [TIME_BITS-1:0] q_per;

  entry_t      tab [MAX_TASKS];
  logic [CW-1:0] count;

  // scan results
  logic [MAX_TASKS-1:0] match_v, first_c, first_oh;
  logic [MAX_TASKS-1:0] before_v;
  logic [MAX_TASKS:0]   bb, ins_c, ins_oh;

  // select results
  logic [IW-1:0] rem_idx;
  logic [CW-1:0] ins_idx;
  logic          found;
  logic [PW-1:0] lo;
  logic [PW:0]   hi;
  entry_t        saved;

  // result registers
  logic [1:0] r_status;
  logic [7:0] r_prio;
  logic [5:0] r_pos;

  function automatic logic goes_before(input logic [1:0] cls,
                                       input logic [TIME_BITS-1:0] dl,
                                       input logic [TIME_BITS-1:0] per,
                                       input entry_t e);
    logic [1:0] gn, ge;
    logic       res;
    gn = group_of(cls);
    ge = group_of(e.cls);
    if (gn != ge) res = (gn < ge);
    else if (gn == GRP_NRT) res = 1'b0;
    else if (dl != e.dl) res = (dl < e.dl);
    else if (gn == GRP_APER) res = 1'b0;
    else res = (per < e.per);
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_req <= req_t'(req_type);
      q_id  <= task_id;
      q_cls <= task_class;
      q_dl  <= deadline;
      q_per <= period_or_frame;
    end
  end

  // midpoint priority from the registered neighbors
  logic [PW:0]   diff, gap;
  logic [PW-1:0] prio_new;
  assign diff = hi - {1'b0, lo};
  assign gap  = (hi > {1'b0, lo}) ? (diff >> 1) : '0;
  assign prio_new = (q_cls == CLS_NRT) ? PRIO_NRT : (lo + gap[PW-1:0]);

  // insert source: new task, or the saved entry on restore
  logic          ins_any;
  logic [CW-1:0] ins_pos;
  logic [CW-1:0] rem_ext;
  entry_t        ins_entry;
  assign ins_any = cmd.insert_new || cmd.insert_saved;
  assign rem_ext = CW'(rem_idx);
  assign ins_pos = cmd.insert_saved ? rem_ext : ins_idx;
  always_comb begin
    if (cmd.insert_saved) begin
      ins_entry    = saved;
      ins_entry.id = q_id;
    end else begin
      ins_entry.id   = q_id;
      ins_entry.cls  = q_cls;
      ins_entry.dl   = q_dl;
      ins_entry.per  = q_per;
      ins_entry.prio = prio_new;
    end
  end

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    localparam logic [MAX_TASKS-1:0] LOW = (MAX_TASKS'(1) << g) - MAX_TASKS'(1);
    entry_t up, down;
    logic   valid;

    if (g < MAX_TASKS - 1) begin : g_up
      assign up = tab[g+1];
    end else begin : g_top
      assign up = tab[g];
    end
    if (g > 0) begin : g_down
      assign down = tab[g-1];
    end else begin : g_bot
      assign down = tab[g];
    end

    assign valid       = (CW'(g) < count);
    assign match_v[g]  = valid && (tab[g].id == q_id);
    assign before_v[g] = goes_before(q_cls, q_dl, q_per, tab[g]);
    assign first_c[g]  = match_v[g] && !(|(match_v & LOW));
    assign bb[g]       = valid ? before_v[g] : 1'b1;

    if (g > 0) begin : g_ins
      assign ins_c[g] = bb[g] && !bb[g-1];
    end else begin : g_ins0
      assign ins_c[g] = bb[g];
    end

    always_ff @(posedge clk) begin
      if (cmd.remove) begin
        if (CW'(g) >= rem_ext) tab[g] <= up;
      end else if (ins_any) begin
        if (CW'(g) > ins_pos) tab[g] <= down;
        else if (CW'(g) == ins_pos) tab[g] <= ins_entry;
      end
    end
  end

  assign bb[MAX_TASKS]    = 1'b1;
  assign ins_c[MAX_TASKS] = !bb[MAX_TASKS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.remove) begin
      count <= count - CW'(1);
    end else if (ins_any) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      first_oh <= first_c;
      ins_oh   <= ins_c;
    end
  end

  // one-hot selects and encodes over the registered scan vectors
  logic [IW-1:0] rem_idx_c;
  logic [CW-1:0] ins_idx_c;
  logic [PW-1:0] lo_c, hi_sel;
  logic          hi_any;
  entry_t        saved_c;
  always_comb begin
    rem_idx_c = '0;
    ins_idx_c = '0;
    lo_c      = '0;
    hi_sel    = '0;
    hi_any    = 1'b0;
    saved_c   = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (first_oh[i]) begin
        rem_idx_c = rem_idx_c | IW'(i);
        saved_c   = saved_c | tab[i];
      end
      if (ins_oh[i+1]) lo_c = lo_c | tab[i].prio;
      if (ins_oh[i] && (CW'(i) < count)) begin
        hi_sel = hi_sel | tab[i].prio;
        hi_any = 1'b1;
      end
    end
    for (int i = 0; i <= MAX_TASKS; i++) begin
      if (ins_oh[i]) ins_idx_c = ins_idx_c | CW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      ins_idx <= ins_idx_c;
      lo      <= lo_c;
      hi      <= hi_any ? {1'b0, hi_sel} : PRIO_TOP;
      if (cmd.select_rem) begin
        rem_idx <= rem_idx_c;
        saved   <= saved_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.select && cmd.select_rem) begin
      found <= |first_oh;
    end
  end

  assign stat.req    = q_req;
  assign stat.found  = found;
  assign stat.full   = (count == CW'(MAX_TASKS));
  assign stat.no_gap = (q_cls != CLS_NRT) && (gap == '0);

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_ZERO: begin
        r_status <= STAT_OK;
        r_prio   <= '0;
        r_pos    <= '0;
      end
      RES_NOT_FOUND: begin
        r_status <= STAT_NOT_FOUND;
        r_prio   <= '0;
        r_pos    <= '0;
      end
      RES_REMOVED: begin
        r_status <= STAT_OK;
        r_prio   <= 8'(saved.prio);
        r_pos    <= 6'(rem_idx);
      end
      RES_FULL: begin
        r_status <= STAT_FULL;
        r_prio   <= '0;
        r_pos    <= '0;
      end
      RES_NO_GAP: begin
        r_status <= STAT_NO_GAP;
        r_prio   <= '0;
        r_pos    <= 6'(ins_idx);
      end
      RES_ADDED: begin
        r_status <= STAT_OK;
        r_prio   <= 8'(prio_new);
        r_pos    <= 6'(ins_idx);
      end
      default: ;
    endcase
    if (cmd.publish) begin
      status            <= r_status;
      assigned_priority <= r_prio;
      position          <= r_pos;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS))
    else $error("entry count beyond table size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_new |-> (count < CW'(MAX_TASKS)))
    else $error("insert into a full table");

  a_remove_found: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> (found && count != '0))
    else $error("remove without a matching entry");

endmodule

### src/deadline_monotonic_priority_table_core.sv
// ----------------------------------------------------------------------------
// deadline_monotonic_priority_table_core
// Deadline-monotonic task table with static priority assignment.
//
// Usage: one request word (add, remove, reschedule) enters on the input
// valid/ready channel; exactly one result word (status, priority, slot)
// leaves on the output valid/ready channel, in request order.
// Throughput: one request at a time. in_ready is high only while the
// sequencer is idle. Steps of each request after it is accepted:
//   add or remove: scan, select, then the add or remove step;
//   unknown request type: scan, select; reschedule: scan, select, remove,
//   scan, select, add, and a restore step if that add fails.
// out_valid rises in the cycle after the hand-off state publishes. The
// result sits in an output register, so the next request is taken while
// a finished word waits; if the receiver still holds the previous word
// when the next one is done, the sequencer waits in its hand-off state.
// Reset (rst, synchronous): the table is emptied (entry count zero), the
// output channel goes invalid and the sequencer returns to idle.
// ----------------------------------------------------------------------------
module deadline_monotonic_priority_table_core #(
  parameter int MAX_TASKS = 32,
  parameter int MAX_PRIO  = 256,
  parameter int TIME_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic [7:0]           task_id,
  input  logic [1:0]           task_class,
  input  logic [TIME_BITS-1:0] deadline,
  input  logic [TIME_BITS-1:0] period_or_frame,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [7:0]           assigned_priority,
  output logic [5:0]           position
);
  import dmpt_pkg::*;

  dmpt_cmd_t  cmd;    // sequencer -> datapath
  dmpt_stat_t stat;   // datapath -> sequencer

  // Sequencer: owns the handshake and the step order of each request.
  dmpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: the sorted cells, compare/select logic and result words.
  dmpt_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_PRIO  (MAX_PRIO),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .req_type          (req_type),
    .task_id           (task_id),
    .task_class        (task_class),
    .deadline          (deadline),
    .period_or_frame   (period_or_frame),
    .status            (status),
    .assigned_priority (assigned_priority),
    .position          (position)
  );

endmodule
